>>> design/lste_pkg.sv
// Shared types, codes and sizes for the link state table engine.
package lste_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = 7;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

  localparam logic [2:0] MODE_INSERT = 3'd0;
  localparam logic [2:0] MODE_EXISTS = 3'd1;
  localparam logic [2:0] MODE_QUERY  = 3'd2;
  localparam logic [2:0] MODE_DUMP   = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;

  localparam logic [2:0] STAT_ADDED     = 3'd0;
  localparam logic [2:0] STAT_UPDATED   = 3'd1;
  localparam logic [2:0] STAT_NOT_NEWER = 3'd2;
  localparam logic [2:0] STAT_FULL      = 3'd3;
  localparam logic [2:0] STAT_MATCH     = 3'd4;
  localparam logic [2:0] STAT_NONE      = 3'd5;
  localparam logic [2:0] STAT_CLEARED   = 3'd6;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] src_router;
    logic [15:0] dst_router;
    logic [31:0] seq_num;
    logic [15:0] cost_in;
    logic [15:0] query_router;
  } lste_in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [15:0]      out_src;
    logic [15:0]      out_dst;
    logic [31:0]      out_seq;
    logic [15:0]      peer_router;
    logic [15:0]      out_cost;
    logic [CNT_W-1:0] entry_count;
    logic             last;
  } lste_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINAL
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } stat_t;

endpackage

>>> design/lste_ctrl.sv
// Controller state machine: accept, slot scan, final result.
module lste_ctrl
  import lste_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] in_mode,
  output logic       in_stall,
  output cmd_t       cmd,
  input  stat_t      stat
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_mode inside {MODE_INSERT, MODE_EXISTS, MODE_QUERY, MODE_DUMP}) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_FINAL;
          end
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_SCAN:  cmd.step   = 1'b1;
      S_FINAL: cmd.finish = 1'b1;
      default: in_stall   = 1'b1;
    endcase
  end

endmodule

>>> design/lste_dp.sv
// Datapath: slot storage, scan evaluation, pending result and output register.
module lste_dp
  import lste_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  lste_in_t  in_data,
  input  cmd_t      cmd,
  output stat_t     stat,
  output logic      out_valid,
  input  logic      out_stall,
  output lste_out_t out_data
);

  // slot storage
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [15:0]            src_r  [TABLE_DEPTH];
  logic [15:0]            dst_r  [TABLE_DEPTH];
  logic [31:0]            seq_r  [TABLE_DEPTH];
  logic [15:0]            cost_r [TABLE_DEPTH];
  logic [CNT_W-1:0]       count_r;

  // per-item scan state
  lste_in_t         item_r;
  logic [IDX_W-1:0] idx_r;
  logic             found_r;
  logic [IDX_W-1:0] found_idx_r;
  logic [31:0]      found_seq_r;
  logic             free_found_r;
  logic [IDX_W-1:0] free_idx_r;
  logic             pend_valid_r;
  lste_out_t        pend_r;

  logic             out_valid_r;
  lste_out_t        out_r;

  logic        cur_vld;
  logic [15:0] cur_src;
  logic [15:0] cur_dst;
  logic [31:0] cur_seq;
  logic [15:0] cur_cost;
  logic        key_hit;
  logic        src_hit;
  logic        dst_hit;
  logic        is_query;
  logic        is_dump;
  logic        scan_match;
  logic        emit;
  logic        hold;
  logic        out_free;
  logic        fin_go;
  logic        out_load;
  lste_out_t   scan_res;
  lste_out_t   fin_res;
  lste_out_t   out_nxt;
  logic        wr_new;
  logic        wr_upd;
  logic        do_clear;
  logic        newer;

  assign cur_vld  = valid_r[idx_r];
  assign cur_src  = src_r[idx_r];
  assign cur_dst  = dst_r[idx_r];
  assign cur_seq  = seq_r[idx_r];
  assign cur_cost = cost_r[idx_r];

  assign key_hit  = cur_vld && (cur_src == item_r.src_router) &&
                    (cur_dst == item_r.dst_router);
  assign dst_hit  = cur_dst == item_r.query_router;
  assign src_hit  = cur_src == item_r.query_router;
  assign is_query = item_r.mode == MODE_QUERY;
  assign is_dump  = item_r.mode == MODE_DUMP;

  assign scan_match = cur_vld && (is_dump || (is_query && (dst_hit || src_hit)));
  assign out_free   = !out_valid_r || !out_stall;
  assign emit       = cmd.step && scan_match;
  // hold the scan while a second listing waits for room
  assign hold       = emit && pend_valid_r && !out_free;
  assign fin_go     = cmd.finish && out_free;
  assign newer      = found_seq_r < item_r.seq_num;

  assign stat.scan_done = cmd.step && !hold && (idx_r == IDX_LAST);
  assign stat.out_free  = out_free;

  always_comb begin
    scan_res             = '0;
    scan_res.status      = STAT_MATCH;
    scan_res.out_cost    = cur_cost;
    scan_res.entry_count = count_r;
    if (is_dump) begin
      scan_res.out_src = cur_src;
      scan_res.out_dst = cur_dst;
      scan_res.out_seq = cur_seq;
    end else begin
      scan_res.peer_router = dst_hit ? cur_src : cur_dst;
    end
  end

  always_comb begin
    fin_res             = '0;
    fin_res.last        = 1'b1;
    fin_res.status      = STAT_NONE;
    fin_res.entry_count = count_r;
    wr_new              = 1'b0;
    wr_upd              = 1'b0;
    do_clear            = 1'b0;
    case (item_r.mode)
      MODE_INSERT: begin
        if (found_r) begin
          if (newer) begin
            wr_upd         = 1'b1;
            fin_res.status = STAT_UPDATED;
          end else begin
            fin_res.status = STAT_NOT_NEWER;
          end
        end else if (free_found_r) begin
          wr_new              = 1'b1;
          fin_res.status      = STAT_ADDED;
          fin_res.entry_count = count_r + CNT_W'(1);
        end else begin
          fin_res.status = STAT_FULL;
        end
      end
      MODE_EXISTS: begin
        if (found_r && (found_seq_r == item_r.seq_num)) begin
          fin_res.status = STAT_MATCH;
        end
      end
      MODE_QUERY, MODE_DUMP: begin
        if (pend_valid_r) begin
          fin_res      = pend_r;
          fin_res.last = 1'b1;
        end
      end
      MODE_CLEAR: begin
        do_clear            = 1'b1;
        fin_res.status      = STAT_CLEARED;
        fin_res.entry_count = '0;
      end
      default: fin_res.status = STAT_NONE;
    endcase
  end

  assign out_load = (emit && !hold && pend_valid_r) || fin_go;
  assign out_nxt  = cmd.finish ? fin_res : pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      count_r      <= '0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      idx_r        <= '0;
    end else begin
      if (cmd.load) begin
        idx_r        <= '0;
        found_r      <= 1'b0;
        free_found_r <= 1'b0;
        pend_valid_r <= 1'b0;
      end
      if (cmd.step) begin
        if (key_hit && !found_r) begin
          found_r <= 1'b1;
        end
        if (!cur_vld && !free_found_r) begin
          free_found_r <= 1'b1;
        end
        if (emit && !hold) begin
          pend_valid_r <= 1'b1;
        end
        if (!hold) begin
          idx_r <= (idx_r == IDX_LAST) ? '0 : idx_r + IDX_W'(1);
        end
      end
      if (fin_go) begin
        pend_valid_r <= 1'b0;
        if (wr_new) begin
          valid_r[free_idx_r] <= 1'b1;
          count_r             <= count_r + CNT_W'(1);
        end
        if (do_clear) begin
          valid_r <= '0;
          count_r <= '0;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.step) begin
      if (key_hit && !found_r) begin
        found_idx_r <= idx_r;
        found_seq_r <= cur_seq;
      end
      if (!cur_vld && !free_found_r) begin
        free_idx_r <= idx_r;
      end
      if (emit && !hold) begin
        pend_r <= scan_res;
      end
    end
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go && wr_new) begin
      src_r[free_idx_r]  <= item_r.src_router;
      dst_r[free_idx_r]  <= item_r.dst_router;
      seq_r[free_idx_r]  <= item_r.seq_num;
      cost_r[free_idx_r] <= item_r.cost_in;
    end else if (fin_go && wr_upd) begin
      seq_r[found_idx_r]  <= item_r.seq_num;
      cost_r[found_idx_r] <= item_r.cost_in;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CNT_W'($countones(valid_r)))
    else $error("entry count differs from number of valid slots");

  a_found_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && found_r) |-> valid_r[found_idx_r])
    else $error("matched slot is not valid at commit");

  a_pend_drained: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> !pend_valid_r)
    else $error("pending listing left behind after final result");

  a_hold_keeps_index: assert property (@(posedge clk) disable iff (!rst_n)
    hold |=> $stable(idx_r))
    else $error("scan index moved while listing was held");
`endif

endmodule

>>> design/link_state_table_engine.sv
// Top level of the link state table engine: controller plus datapath.
// Insert, exists, neighbor query and dump scan every slot, one per cycle unless a held listing
// stalls the scan; the final result then waits while out_stall holds.
// Clear and unused modes skip the scan. One item is in flight at a time.
// The final result follows the scan (directly for clear); a listing runs one match behind.
// Reset empties the table at once (valid bits and count clear); slot data is not reset.
module link_state_table_engine
  import lste_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  lste_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output lste_out_t out_data
);

  cmd_t  cmd;
  stat_t stat;

  lste_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  lste_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
